@@ rtl/slpg_pkg.sv @@
package slpg_pkg;

    // Opcodes of an input item.
    localparam logic [1:0] OP_REFRESH  = 2'd0;
    localparam logic [1:0] OP_SET_BASE = 2'd1;
    localparam logic [1:0] OP_OVERLAY  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_BRIGHTNESS = 1'b0;
    localparam logic CFG_SWAP       = 1'b1;

    // Status codes.
    localparam logic [3:0] ST_BOOT       = 4'd0;
    localparam logic [3:0] ST_PROVISION  = 4'd1;
    localparam logic [3:0] ST_OFFLINE    = 4'd2;
    localparam logic [3:0] ST_CONNECTING = 4'd3;
    localparam logic [3:0] ST_ONLINE     = 4'd4;
    localparam logic [3:0] ST_SENDING    = 4'd5;
    localparam logic [3:0] ST_SEND_OK    = 4'd6;
    localparam logic [3:0] ST_SEND_FAIL  = 4'd7;
    localparam logic [3:0] ST_UPDATE     = 4'd8;
    localparam logic [3:0] ST_LOW_BATT   = 4'd9;

    localparam int PERIOD_W   = 12;
    localparam int NIBBLES    = 8;
    localparam int CNT_W      = 3;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NIBBLES - 1);

    // Breathe triangle: x*255/1500 is floor(x*17/100), and v/100 is
    // (v*5243) >> 19 for every v the triangle produces.
    localparam int unsigned TRI_PERIOD = 3000;
    localparam int unsigned TRI_HALF   = 1500;
    localparam int unsigned TRI_MUL    = 17;
    localparam int unsigned DIV100_MUL = 5243;
    localparam int unsigned DIV100_SH  = 19;
    localparam int unsigned BREATHE_FLOOR = 40;

    typedef logic [PERIOD_W-1:0] t_period;

    // Microprogram step indexes.
    typedef logic [2:0] t_pc;
    localparam t_pc PC_WAIT   = 3'd0;
    localparam t_pc PC_SELECT = 3'd1;
    localparam t_pc PC_MOD    = 3'd2;
    localparam t_pc PC_TRI1   = 3'd3;
    localparam t_pc PC_TRI2   = 3'd4;
    localparam t_pc PC_COLOR  = 3'd5;
    localparam t_pc PC_SCALE  = 3'd6;

    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_SELECT,
        UOP_MOD,
        UOP_TRI1,
        UOP_TRI2,
        UOP_COLOR,
        UOP_SCALE
    } t_uop;

    // Condition under which the step counter holds on the current step.
    typedef enum logic [1:0] {
        STAY_NEVER,
        STAY_NO_INPUT,
        STAY_MOD_MORE,
        STAY_OUT_BUSY
    } t_stay;

    typedef struct packed {
        t_uop  uop;
        t_stay stay;
        t_pc   next;
    } t_uword;

    typedef struct packed {
        logic clear;
        logic step;
    } t_mod_ctl;

    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_WAIT:   w = '{uop: UOP_WAIT,   stay: STAY_NO_INPUT, next: PC_SELECT};
            PC_SELECT: w = '{uop: UOP_SELECT, stay: STAY_NEVER,    next: PC_MOD};
            PC_MOD:    w = '{uop: UOP_MOD,    stay: STAY_MOD_MORE, next: PC_TRI1};
            PC_TRI1:   w = '{uop: UOP_TRI1,   stay: STAY_NEVER,    next: PC_TRI2};
            PC_TRI2:   w = '{uop: UOP_TRI2,   stay: STAY_NEVER,    next: PC_COLOR};
            PC_COLOR:  w = '{uop: UOP_COLOR,  stay: STAY_NEVER,    next: PC_SCALE};
            PC_SCALE:  w = '{uop: UOP_SCALE,  stay: STAY_OUT_BUSY, next: PC_WAIT};
            default:   w = '{uop: UOP_WAIT,   stay: STAY_NEVER,    next: PC_WAIT};
        endcase
        return w;
    endfunction

    // Blink period of each status; solid colors and the breathe use the
    // triangle period.
    function automatic t_period status_period(input logic [3:0] st);
        t_period p;
        case (st)
            ST_OFFLINE:    p = t_period'(1400);
            ST_CONNECTING: p = t_period'(400);
            ST_SEND_OK:    p = t_period'(240);
            ST_SEND_FAIL:  p = t_period'(240);
            ST_UPDATE:     p = t_period'(300);
            ST_LOW_BATT:   p = t_period'(150);
            default:       p = t_period'(TRI_PERIOD);
        endcase
        return p;
    endfunction

endpackage

@@ rtl/slpg_mod_unit.sv @@
module slpg_mod_unit import slpg_pkg::*; (
    input  logic     i_clk,
    input  t_mod_ctl i_ctl,
    input  logic [3:0] i_nibble,
    input  t_period  i_period,
    output t_period  o_rem
);

    logic [PERIOD_W+3:0] v;
    logic [PERIOD_W+3:0] sub;
    t_period r_rem;

    // Shift one nibble into the remainder; the value is below 16 periods,
    // so four conditional subtractions of 8P, 4P, 2P and P bring it back.
    always_comb begin
        v   = {r_rem, i_nibble};
        sub = '0;
        for (int k = 3; k >= 0; k--) begin
            sub = {4'd0, i_period} << k;
            if (v >= sub) begin
                v = v - sub;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_rem <= v[PERIOD_W-1:0];
        end
    end

    assign o_rem = r_rem;

endmodule

@@ rtl/status_led_pattern_generator.sv @@
// An accepted item runs through the steps in order: taking the item, picking
// the status, the modulo of the time (one nibble a step in the remainder
// unit), the breathe and color steps, and scaling. A new item is taken only
// once the result of the last one has been loaded into the output register.
// Reset (synchronous, active low) clears the status, overlay and output valid,
// sets brightness to 32 and swap to off, and restarts the microprogram.
module status_led_pattern_generator import slpg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_status_code,
    input  logic [31:0] i_duration_ms,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_wire_first,
    output logic [7:0]  o_wire_second,
    output logic [7:0]  o_wire_blue,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    // The sequencer: a step counter addresses a small control store. Each
    // control word names the datapath operation of the step, a condition to
    // hold on the step, and the step that follows.
    t_pc    r_pc;
    t_uword w;
    logic   stay;

    // Kept state and configuration.
    logic [7:0]  r_brightness;
    logic        r_swap;
    logic [3:0]  r_base;
    logic [3:0]  r_overlay;
    logic [31:0] r_deadline;

    // Working registers of one item.
    logic [31:0]      r_now;
    logic [3:0]       r_show;
    logic [CNT_W-1:0] r_cnt;
    logic [14:0]      r_acc;
    logic [7:0]       r_red;
    logic [7:0]       r_green;
    logic [7:0]       r_blue;
    logic [7:0]       n_red;
    logic [7:0]       n_green;
    logic [7:0]       n_blue;

    // Output register.
    logic       r_o_valid;
    logic [7:0] r_first;
    logic [7:0] r_second;
    logic [7:0] r_wblue;

    logic        in_fire;
    logic        out_free;
    logic [31:0] deadline_sum;
    logic [31:0] diff;
    logic        overlay_live;
    t_period     period;
    t_period     rem;
    t_mod_ctl    mod_ctl;
    logic [10:0] tri_x;
    logic [27:0] tri_prod;
    logic [9:0]  tri_x3;
    logic [7:0]  breathe;
    logic        blink;
    logic [15:0] p_red;
    logic [15:0] p_green;
    logic [15:0] p_blue;
    logic [16:0] q_red;
    logic [16:0] q_green;
    logic [16:0] q_blue;

    assign w        = ucode_rom(r_pc);
    assign o_ready  = (w.uop == UOP_WAIT);
    assign in_fire  = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    always_comb begin
        case (w.stay)
            STAY_NO_INPUT: stay = !i_valid;
            STAY_MOD_MORE: stay = (r_cnt != CNT_LAST);
            STAY_OUT_BUSY: stay = !out_free;
            default:       stay = 1'b0;
        endcase
    end

    // A new overlay deadline never reads as zero, since zero marks no overlay.
    assign deadline_sum = i_now_ms + i_duration_ms;

    // The overlay is shown while its deadline lies strictly ahead of now,
    // judged on the wrapped difference.
    assign diff         = r_deadline - r_now;
    assign overlay_live = (r_deadline != 32'd0) && (diff != 32'd0) && !diff[31];

    // The remainder unit divides the time by the period of the shown status,
    // one nibble per step from the top down.
    assign period  = status_period(r_show);
    assign mod_ctl = '{clear: (w.uop == UOP_SELECT), step: (w.uop == UOP_MOD)};

    slpg_mod_unit u_mod (
        .i_clk    (i_clk),
        .i_ctl    (mod_ctl),
        .i_nibble (r_now[31:28]),
        .i_period (period),
        .o_rem    (rem)
    );

    // Breathe: fold the phase into a rising and falling ramp, then scale to
    // 0..255 over two registered steps and add three quarters of it to the floor.
    assign tri_x    = (rem < t_period'(TRI_HALF)) ? rem[10:0]
                                                   : 11'(t_period'(TRI_PERIOD) - rem);
    assign tri_prod = 28'(r_acc) * 28'(DIV100_MUL);
    assign tri_x3   = 10'(r_acc[7:0]) * 10'd3;
    assign breathe  = 8'(BREATHE_FLOOR) + 8'(tri_x3 >> 2);
    assign blink    = (rem < (period >> 1));

    // Color of the shown status before scaling.
    always_comb begin
        n_red   = 8'd0;
        n_green = 8'd0;
        n_blue  = 8'd0;
        case (r_show)
            ST_BOOT: begin
                n_red   = 8'd70;
                n_green = 8'd45;
            end
            ST_PROVISION: begin
                n_red  = 8'd90;
                n_blue = 8'd90;
            end
            ST_OFFLINE:    n_red   = blink ? 8'd140 : 8'd0;
            ST_CONNECTING: n_blue  = blink ? 8'd150 : 8'd0;
            ST_ONLINE:     n_green = breathe;
            ST_SENDING: begin
                n_green = 8'd80;
                n_blue  = 8'd90;
            end
            ST_SEND_OK:    n_green = blink ? 8'd170 : 8'd0;
            ST_SEND_FAIL:  n_red   = blink ? 8'd170 : 8'd0;
            ST_UPDATE: begin
                n_red   = blink ? 8'd140 : 8'd0;
                n_green = blink ? 8'd140 : 8'd0;
                n_blue  = blink ? 8'd140 : 8'd0;
            end
            ST_LOW_BATT:   n_red   = blink ? 8'd170 : 8'd0;
            // Codes without a color stay dark.
            default:       n_blue  = 8'd0;
        endcase
    end

    // Scaling by brightness/255: for a 16-bit product v, v/255 equals
    // (v + (v >> 8) + 1) >> 8.
    assign p_red   = 16'(r_red) * 16'(r_brightness);
    assign p_green = 16'(r_green) * 16'(r_brightness);
    assign p_blue  = 16'(r_blue) * 16'(r_brightness);
    assign q_red   = 17'(p_red) + 17'(p_red >> 8) + 17'd1;
    assign q_green = 17'(p_green) + 17'(p_green >> 8) + 17'd1;
    assign q_blue  = 17'(p_blue) + 17'(p_blue >> 8) + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= PC_WAIT;
            r_brightness <= 8'd32;
            r_swap       <= 1'b0;
            r_base       <= ST_BOOT;
            r_overlay    <= ST_BOOT;
            r_deadline   <= 32'd0;
            r_o_valid    <= 1'b0;
        end else begin
            if (!stay) begin
                r_pc <= w.next;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BRIGHTNESS: r_brightness <= i_cfg_wdata;
                    CFG_SWAP:       r_swap       <= i_cfg_wdata[0];
                    default:        r_swap       <= r_swap;
                endcase
            end

            // A finished item loads the output register as soon as it is free;
            // otherwise a taken result empties it.
            if (w.uop == UOP_SCALE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (w.uop)
                UOP_WAIT: begin
                    if (in_fire) begin
                        r_now <= i_now_ms;
                        if (i_opcode == OP_SET_BASE) begin
                            r_base <= i_status_code;
                        end else if (i_opcode == OP_OVERLAY) begin
                            r_overlay  <= i_status_code;
                            r_deadline <= (deadline_sum == 32'd0) ? 32'd1 : deadline_sum;
                        end
                    end
                end
                UOP_SELECT: begin
                    r_cnt <= '0;
                    if (overlay_live) begin
                        r_show <= r_overlay;
                    end else begin
                        r_show     <= r_base;
                        r_deadline <= 32'd0;
                    end
                end
                UOP_MOD: begin
                    r_now <= r_now << 4;
                    r_cnt <= r_cnt + 1'b1;
                end
                UOP_TRI1: begin
                    r_acc <= 15'(tri_x) * 15'(TRI_MUL);
                end
                UOP_TRI2: begin
                    r_acc <= 15'(tri_prod[DIV100_SH+7:DIV100_SH]);
                end
                UOP_COLOR: begin
                    r_red   <= n_red;
                    r_green <= n_green;
                    r_blue  <= n_blue;
                end
                UOP_SCALE: begin
                    if (out_free) begin
                        r_first  <= r_swap ? q_green[15:8] : q_red[15:8];
                        r_second <= r_swap ? q_red[15:8] : q_green[15:8];
                        r_wblue  <= q_blue[15:8];
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_wire_first  = r_first;
    assign o_wire_second = r_second;
    assign o_wire_blue   = r_wblue;

endmodule

@@ sim/tb_status_led_pattern_generator.sv @@
`timescale 1ns / 1ps

module tb_status_led_pattern_generator;
    import slpg_pkg::*;

    // Opcode 3 has no function of its own; the block treats it as a refresh.
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    // Status codes above low battery have no color and render dark.
    localparam logic [3:0] ST_UNDEF_FIRST = 4'd10;
    localparam logic [3:0] ST_UNDEF_LAST  = 4'd15;

    // Cycles with no item accepted and no result taken before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off plus one item.
    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    // Quiet cycles after the last result, to catch anything extra.
    localparam int DRAIN_CYCLES    = 30;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] blue;
    } t_led_rgb;

    // Clock, reset and every block input start at known values.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [1:0]  i_opcode      = OP_REFRESH;
    logic [3:0]  i_status_code = ST_BOOT;
    logic [31:0] i_duration_ms = 32'd0;
    logic [31:0] i_now_ms      = 32'd0;
    logic        i_ready       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = CFG_BRIGHTNESS;
    logic [7:0]  i_cfg_wdata   = 8'd0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_wire_first;
    logic [7:0]  o_wire_second;
    logic [7:0]  o_wire_blue;

    status_led_pattern_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_status_code (i_status_code),
        .i_duration_ms (i_duration_ms),
        .i_now_ms      (i_now_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_wire_first  (o_wire_first),
        .o_wire_second (o_wire_second),
        .o_wire_blue   (o_wire_blue),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the block's state and configuration, advanced once per
    // accepted item and once per register write.
    logic [7:0]  shadow_brightness = 8'd32;
    logic        shadow_swap       = 1'b0;
    logic [3:0]  shadow_base       = ST_BOOT;
    logic [3:0]  shadow_overlay    = ST_BOOT;
    logic [31:0] shadow_deadline   = 32'd0;

    // Colors still owed by the block, oldest first.
    t_led_rgb expected_leds[$];
    t_led_rgb oldest_leds;

    int items_sent      = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int error_count     = 0;
    int quiet_cycles    = 0;

    // Test control shared with the receiver process.
    bit idle_enable  = 1'b1;
    bit hold_request = 1'b0;

    // Running millisecond clock for well-formed traffic.
    logic [31:0] clock_ms = 32'd0;

    // A blink is lit during the first half of each period.
    function automatic bit blink_lit(input logic [31:0] now_v, input int unsigned period);
        return (now_v % period) < (period / 2);
    endfunction

    // Online breathe: a 0..255..0 triangle over 3 s, taken at 3/4 on a floor of 40.
    function automatic int unsigned breathe_level(input logic [31:0] now_v);
        int unsigned phase;
        int unsigned rise;
        phase = now_v % 3000;
        rise  = (phase < 1500) ? phase : 3000 - phase;
        return 40 + (((rise * 255) / 1500) * 3) / 4;
    endfunction

    function automatic int unsigned scale_channel(input int unsigned level);
        return ((level & 8'hFF) * shadow_brightness) / 255;
    endfunction

    // Applies one item to the shadow state and returns the color it shows.
    function automatic t_led_rgb predict_leds(input logic [1:0] op, input logic [3:0] code,
                                              input logic [31:0] dur, input logic [31:0] now_v);
        logic [3:0]  shown;
        logic [31:0] ahead;
        int unsigned red;
        int unsigned green;
        int unsigned blue;
        t_led_rgb    leds;
        if (op == OP_SET_BASE) begin
            shadow_base = code;
        end else if (op == OP_OVERLAY) begin
            shadow_overlay  = code;
            shadow_deadline = now_v + dur;
            // Zero is reserved for "no overlay", so a deadline landing on it moves to 1.
            if (shadow_deadline == 32'd0)
                shadow_deadline = 32'd1;
        end
        shown = shadow_base;
        if (shadow_deadline != 32'd0) begin
            // Wrap-safe compare: the overlay holds while the deadline is strictly ahead.
            ahead = shadow_deadline - now_v;
            if (ahead != 32'd0 && !ahead[31])
                shown = shadow_overlay;
            else
                shadow_deadline = 32'd0;
        end
        red   = 0;
        green = 0;
        blue  = 0;
        case (shown)
            ST_BOOT: begin
                red   = 70;
                green = 45;
            end
            ST_PROVISION: begin
                red  = 90;
                blue = 90;
            end
            ST_OFFLINE:    red   = blink_lit(now_v, 1400) ? 140 : 0;
            ST_CONNECTING: blue  = blink_lit(now_v, 400) ? 150 : 0;
            ST_ONLINE:     green = breathe_level(now_v);
            ST_SENDING: begin
                green = 80;
                blue  = 90;
            end
            ST_SEND_OK:    green = blink_lit(now_v, 240) ? 170 : 0;
            ST_SEND_FAIL:  red   = blink_lit(now_v, 240) ? 170 : 0;
            ST_UPDATE: begin
                red   = blink_lit(now_v, 300) ? 140 : 0;
                green = red;
                blue  = red;
            end
            ST_LOW_BATT:   red   = blink_lit(now_v, 150) ? 170 : 0;
            default: ;
        endcase
        red   = scale_channel(red);
        green = scale_channel(green);
        blue  = scale_channel(blue);
        leds.first  = shadow_swap ? green[7:0] : red[7:0];
        leds.second = shadow_swap ? red[7:0] : green[7:0];
        leds.blue   = blue[7:0];
        return leds;
    endfunction

    task automatic log_error(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Offers one item and returns once it has been accepted. Valid is left
    // high so a following item can be offered back to back; anything that
    // waits afterwards must call sender_stop first.
    task automatic send_item(input logic [1:0] op, input logic [3:0] code,
                             input logic [31:0] dur, input logic [31:0] now_v);
        @(negedge i_clk);
        while (idle_enable && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_status_code <= code;
        i_duration_ms <= dur;
        i_now_ms      <= now_v;
        do
            @(posedge i_clk);
        while (!o_ready);
        expected_leds.push_back(predict_leds(op, code, dur, now_v));
        items_sent++;
    endtask

    task automatic sender_stop();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Stops offering and waits for every owed result. The watchdog guards this.
    task automatic wait_drained();
        sender_stop();
        while (expected_leds.size() != 0)
            @(posedge i_clk);
    endtask

    // Registers are only written with nothing in flight.
    task automatic write_config(input logic index, input logic [7:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_BRIGHTNESS)
            shadow_brightness = data;
        else
            shadow_swap = data[0];
        cfg_writes++;
    endtask

    // One item of plausible traffic: the clock mostly creeps forward, now and
    // then it jumps anywhere. Durations are mostly short so overlays start and
    // expire within a phase; some sit on the signed half-range boundary.
    task automatic send_random_item();
        logic [1:0]  op;
        logic [3:0]  code;
        logic [31:0] dur;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 3)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(80);
        pick = $urandom_range(99);
        if (pick < 55)
            op = OP_REFRESH;
        else if (pick < 72)
            op = OP_SET_BASE;
        else if (pick < 95)
            op = OP_OVERLAY;
        else
            op = OP_UNUSED;
        if ($urandom_range(99) < 8)
            code = 4'($urandom_range(ST_UNDEF_LAST, ST_UNDEF_FIRST));
        else
            code = 4'($urandom_range(ST_LOW_BATT));
        pick = $urandom_range(99);
        if (pick < 80)
            dur = $urandom_range(3000);
        else if (pick < 90)
            dur = 32'h8000_0000 - 32'($urandom_range(2));
        else
            dur = $urandom();
        send_item(op, code, dur, clock_ms);
    endtask

    // Receiver: takes results with random stalls, or holds off for a long
    // counted stretch when a test asks for it.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_ready <= !(idle_enable && $urandom_range(99) < 15);
            end
        end
    end

    // Result checker: every accepted color is compared with the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_leds.size() == 0) begin
                log_error($sformatf("result %0d/%0d/%0d arrived with nothing owed",
                                    o_wire_first, o_wire_second, o_wire_blue));
            end else begin
                oldest_leds = expected_leds.pop_front();
                results_checked++;
                if (o_wire_first !== oldest_leds.first || o_wire_second !== oldest_leds.second
                        || o_wire_blue !== oldest_leds.blue)
                    log_error($sformatf("result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                        results_checked, oldest_leds.first,
                                        oldest_leds.second, oldest_leds.blue,
                                        o_wire_first, o_wire_second, o_wire_blue));
            end
        end
    end

    // Watchdog: a run that stops moving items is a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles, %0d results owed",
                         STALL_LIMIT, expected_leds.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Out of reset the block shows boot amber at brightness 32, unswapped.
    task automatic test_reset_defaults();
        idle_enable = 1'b1;
        send_item(OP_REFRESH, ST_BOOT, 32'd0, 32'd0);
        send_item(OP_REFRESH, ST_OFFLINE, 32'd500, 32'd123);
        send_item(OP_REFRESH, ST_BOOT, 32'd0, 32'hFFFF_FFFF);
    endtask

    // Every status color, blink edges, the breathe peak and floor, and the
    // overlay corner cases, all at full brightness.
    task automatic test_directed_cases();
        write_config(CFG_BRIGHTNESS, 8'd255);
        send_item(OP_SET_BASE, ST_PROVISION, 32'd0, 32'd0);
        // Offline is lit up to 699 and dark from 700.
        send_item(OP_SET_BASE, ST_OFFLINE, 32'd0, 32'd699);
        send_item(OP_REFRESH, ST_BOOT, 32'd0, 32'd700);
        send_item(OP_SET_BASE, ST_CONNECTING, 32'd0, 32'd199);
        send_item(OP_REFRESH, ST_BOOT, 32'd0, 32'd200);
        // Breathe at its peak, at its floor and at the very end of time.
        send_item(OP_SET_BASE, ST_ONLINE, 32'd0, 32'd1500);
        send_item(OP_REFRESH, ST_BOOT, 32'd0, 32'd6000);
        send_item(OP_REFRESH, ST_BOOT, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_SET_BASE, ST_SENDING, 32'd0, 32'd5);
        send_item(OP_SET_BASE, ST_SEND_OK, 32'd0, 32'd119);
        send_item(OP_SET_BASE, ST_SEND_FAIL, 32'd0, 32'd120);
        send_item(OP_SET_BASE, ST_UPDATE, 32'd0, 32'd149);
        send_item(OP_SET_BASE, ST_LOW_BATT, 32'd0, 32'd74);
        // An undefined status renders dark.
        send_item(OP_SET_BASE, ST_UNDEF_LAST, 32'd0, 32'd1);
        // A zero-length overlay expires on the very item that starts it.
        send_item(OP_OVERLAY, ST_SEND_OK, 32'd0, 32'd1000);
        // A deadline that wraps onto zero is kept as 1: shown at 0, gone at 1.
        send_item(OP_SET_BASE, ST_BOOT, 32'd0, 32'd0);
        send_item(OP_OVERLAY, ST_UPDATE, 32'd1, 32'hFFFF_FFFF);
        send_item(OP_REFRESH, ST_BOOT, 32'd0, 32'd0);
        send_item(OP_REFRESH, ST_BOOT, 32'd0, 32'd1);
        // The longest overlay that still lies ahead, refreshed by the unused opcode.
        send_item(OP_OVERLAY, ST_UNDEF_FIRST, 32'h7FFF_FFFF, 32'd0);
        send_item(OP_UNUSED, ST_BOOT, 32'd0, 32'h7FFF_FFFE);
        send_item(OP_UNUSED, ST_BOOT, 32'd0, 32'h7FFF_FFFF);
        // A full-range duration reads as a deadline in the past.
        send_item(OP_OVERLAY, ST_OFFLINE, 32'hFFFF_FFFF, 32'd5);
    endtask

    // Brightness and swap at their extremes, each with a burst of traffic.
    task automatic test_config_extremes();
        logic [7:0] levels [4];
        levels = '{8'd0, 8'd255, 8'd1, 8'd128};
        for (int s = 0; s < 4; s++) begin
            write_config(CFG_BRIGHTNESS, levels[s]);
            write_config(CFG_SWAP, (s % 2 == 1) ? 8'hFF : 8'h00);
            for (int n = 0; n < 25; n++)
                send_random_item();
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the block backs up and must stall its input without losing anything.
    task automatic test_receiver_hold_off();
        wait_drained();
        hold_request = 1'b1;
        for (int n = 0; n < 20; n++)
            send_random_item();
    endtask

    // The sender goes quiet until everything owed has come back, then resumes.
    task automatic test_sender_pause();
        for (int n = 0; n < 10; n++)
            send_random_item();
        wait_drained();
        for (int n = 0; n < 10; n++)
            send_random_item();
    endtask

    // Bulk random traffic in phases, each with its own register settings. One
    // phase runs with no idling on either side; two start near the wrap of time.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            write_config(CFG_BRIGHTNESS, 8'($urandom_range(255)));
            write_config(CFG_SWAP, 8'($urandom_range(1)));
            idle_enable = (phase != 2);
            if (phase == 1 || phase == 4)
                clock_ms = 32'hFFFF_F000 + $urandom_range(2048);
            for (int n = 0; n < 230; n++)
                send_random_item();
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_config_extremes();
        test_receiver_hold_off();
        test_sender_pause();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items and checked %0d colors over %0d register writes,", items_sent,
                 results_checked, cfg_writes);
        $display("covering all status colors, overlay expiry, time wrap and back-pressure.");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d errors in total", error_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ status_led_pattern_generator.f @@
rtl/slpg_pkg.sv
rtl/slpg_mod_unit.sv
rtl/status_led_pattern_generator.sv
sim/tb_status_led_pattern_generator.sv
